FILE: hdl/mpc_pkg.sv
package mpc_pkg;

  // Widths of the coordinate datapath and of the item fields.
  localparam int unsigned CoordW  = 64;
  localparam int unsigned StepW   = 63;
  localparam int unsigned ProdW   = 128;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned IterW   = 12;
  localparam int unsigned IndexW  = 10;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned CfgIdxW = 3;

  // The hue divider works on values up to 255 * 4094, which fit in 20 bits.
  localparam int unsigned DivW = 20;
  localparam int unsigned QuoW = 8;
  localparam int unsigned SecW = 3;
  localparam int unsigned BitW = 3;

  localparam logic [ColorW-1:0] ColorMax = 8'd255;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_X      = 3'd0,
    REG_MIN_Y      = 3'd1,
    REG_STEP_X     = 3'd2,
    REG_STEP_Y     = 3'd3,
    REG_ITER_LIMIT = 3'd4
  } reg_idx_e;

  // Pixel sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CR,
    ST_CI,
    ST_SQA,
    ST_SQB,
    ST_TEST,
    ST_AB,
    ST_RE1,
    ST_RE2,
    ST_IM,
    ST_DIVS,
    ST_DIVM,
    ST_DIVH,
    ST_FIN
  } state_e;

endpackage

FILE: hdl/mpc_mul.sv
// Signed 64 x 64 to 128 bit multiplier built from one 32 x 32 partial product
// per cycle. A start captures the operand magnitudes; the product is valid in
// the cycle in which done_o is high.
module mpc_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mpc_pkg::CoordW-1:0]     op_a_i,
  input  logic [mpc_pkg::CoordW-1:0]     op_b_i,
  output logic                           done_o,
  output logic [mpc_pkg::ProdW-1:0]      product_o
);

  localparam logic [2:0] StepAccLast = 3'd4;
  localparam logic [2:0] StepNeg     = 3'd5;

  logic                         busy_q;
  logic                         done_q;
  logic [2:0]                   cnt_q;
  logic                         neg_q;
  logic [mpc_pkg::CoordW-1:0]   mag_a_q;
  logic [mpc_pkg::CoordW-1:0]   mag_b_q;
  logic [mpc_pkg::CoordW-1:0]   pp_q;
  logic [1:0]                   pp_sh_q;
  logic [mpc_pkg::ProdW-1:0]    acc_q;

  logic [mpc_pkg::HalfW-1:0]    half_a;
  logic [mpc_pkg::HalfW-1:0]    half_b;
  logic [mpc_pkg::ProdW-1:0]    pp_aligned;

  // Partial product order: low*low, low*high, high*low, high*high.
  assign half_a = cnt_q[1] ? mag_a_q[mpc_pkg::CoordW-1:mpc_pkg::HalfW]
                           : mag_a_q[mpc_pkg::HalfW-1:0];
  assign half_b = cnt_q[0] ? mag_b_q[mpc_pkg::CoordW-1:mpc_pkg::HalfW]
                           : mag_b_q[mpc_pkg::HalfW-1:0];

  assign pp_aligned = mpc_pkg::ProdW'(pp_q) << {pp_sh_q, 5'b0};

  // Control: run six steps after a start, then pulse done.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == StepNeg) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 3'd1;
      end
    end
  end

  // Datapath: magnitudes, partial products, accumulation and final sign.
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      mag_a_q <= op_a_i[mpc_pkg::CoordW-1] ? (~op_a_i + 64'd1) : op_a_i;
      mag_b_q <= op_b_i[mpc_pkg::CoordW-1] ? (~op_b_i + 64'd1) : op_b_i;
      neg_q   <= op_a_i[mpc_pkg::CoordW-1] ^ op_b_i[mpc_pkg::CoordW-1];
      acc_q   <= '0;
    end else if (busy_q) begin
      if (cnt_q < StepAccLast) begin
        pp_q    <= half_a * half_b;
        pp_sh_q <= 2'(cnt_q[1]) + 2'(cnt_q[0]);
      end
      if (cnt_q != 3'd0 && cnt_q <= StepAccLast) begin
        acc_q <= acc_q + pp_aligned;
      end else if (cnt_q == StepNeg && neg_q) begin
        acc_q <= ~acc_q + 128'd1;
      end
    end
  end

  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

FILE: hdl/mandelbrot_pixel_color_core.sv
// Mandelbrot pixel colorer. Each transfer on the input channel carries a pixel
// column and row; the block maps them to c = min + index * step in signed
// fixed point with FRAC_BITS fraction bits, iterates z = z*z + c from z = c up
// to the iteration limit, and returns one result: the iteration count at escape
// (|z|^2 > 4, or a saturated part of z) with a six-sector hue ramp, or black
// with iterations equal to the limit when the point does not escape. All
// multiplications run on one shared 64 x 64 multiplier that forms one 32 x 32
// partial product per cycle, and each update of z uses three products:
// a*a, b*b and a*b. After an escape the block runs the sector division
// and the hue division before it loads the result register. A result
// that waits for out_ready_i holds the block in its last state. Only one
// pixel is in flight, and in_ready_o is high while the block is idle, also
// while a finished result waits in the output register.
// Configuration writes are taken at any time and must only be made while idle.
module mandelbrot_pixel_color_core #(
  parameter int unsigned COLUMNS   = 640,
  parameter int unsigned ROWS      = 640,
  parameter int unsigned FRAC_BITS = 56
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [mpc_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mpc_pkg::CoordW-1:0]      cfg_data_i,
  // Pixel input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mpc_pkg::IndexW-1:0]      column_i,
  input  logic [mpc_pkg::IndexW-1:0]      row_i,
  // Color output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mpc_pkg::ColorW-1:0]      red_o,
  output logic [mpc_pkg::ColorW-1:0]      green_o,
  output logic [mpc_pkg::ColorW-1:0]      blue_o,
  output logic [mpc_pkg::IterW-1:0]       iterations_o,
  output logic                            escaped_o
);

  localparam logic [mpc_pkg::CoordW-1:0] MinRst =
      64'd0 - (64'd2 << FRAC_BITS);
  localparam logic [mpc_pkg::StepW-1:0] StepXRst =
      63'((64'd4 << FRAC_BITS) / COLUMNS);
  localparam logic [mpc_pkg::StepW-1:0] StepYRst =
      63'((64'd4 << FRAC_BITS) / ROWS);
  localparam logic [mpc_pkg::IterW-1:0] IterLimitRst = 12'd80;
  localparam logic [mpc_pkg::ProdW-1:0] EscLimit =
      128'd1 << (2 * FRAC_BITS + 2);
  // Sector quotient is at most five (three bits); ramp quotient is below 255.
  localparam logic [mpc_pkg::BitW-1:0] DivSecTop = 3'd2;
  localparam logic [mpc_pkg::BitW-1:0] DivHueTop = 3'd7;

  mpc_pkg::state_e state_q, state_d;

  logic                          issued_q;
  logic                          out_valid_q;
  logic [mpc_pkg::CoordW-1:0]    min_x_q, min_y_q;
  logic [mpc_pkg::StepW-1:0]     step_x_q, step_y_q;
  logic [mpc_pkg::IterW-1:0]     iter_limit_q;

  logic [mpc_pkg::IndexW-1:0]    col_q, row_q;
  logic [mpc_pkg::CoordW-1:0]    cr_q, ci_q, a_q, b_q;
  logic [mpc_pkg::ProdW-1:0]     aa_q, bb_q, ab_q, diff_q;
  logic                          sat_q, first_q, esc_q;
  logic [mpc_pkg::IterW-1:0]     n_q;
  logic [mpc_pkg::DivW-1:0]      rem_q;
  logic [mpc_pkg::QuoW-1:0]      quo_q;
  logic [mpc_pkg::BitW-1:0]      k_q;
  logic [mpc_pkg::SecW-1:0]      sec_q;
  logic [mpc_pkg::ColorW-1:0]    red_q, green_q, blue_q;
  logic [mpc_pkg::IterW-1:0]     iter_q;
  logic                          escd_q;

  logic                          mul_start, mul_done, mul_state;
  logic [mpc_pkg::CoordW-1:0]    mul_a, mul_b;
  logic [mpc_pkg::ProdW-1:0]     mul_prod;
  logic [mpc_pkg::CoordW-1:0]    coord_sum;

  logic [mpc_pkg::ProdW-1:0]     cr_ext, ci_ext, re_sum, im_sum, mag_sum;
  logic [mpc_pkg::CoordW:0]      re_red, im_red;
  logic                          beyond, last_iter, esc_now;

  logic [mpc_pkg::DivW-1:0]      six_n, hue_scaled, div_trial, rem_next;
  logic                          div_fits;
  logic [mpc_pkg::QuoW-1:0]      quo_next;
  logic [mpc_pkg::ColorW-1:0]    rise, fall, red_c, green_c, blue_c;
  logic                          out_load;

  // Floor-shifted value to signed 64 bits; top bit flags saturation.
  function automatic logic [mpc_pkg::CoordW:0] sat_reduce(
      input logic [mpc_pkg::ProdW-1:0] q);
    logic fits;
    fits = (&q[mpc_pkg::ProdW-1:mpc_pkg::CoordW-1]) |
           (~|q[mpc_pkg::ProdW-1:mpc_pkg::CoordW-1]);
    if (fits) begin
      return {1'b0, q[mpc_pkg::CoordW-1:0]};
    end else if (q[mpc_pkg::ProdW-1]) begin
      return {1'b1, 1'b1, {(mpc_pkg::CoordW-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(mpc_pkg::CoordW-1){1'b1}}};
    end
  endfunction

  // Shared multiplier.
  mpc_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .op_a_i    (mul_a),
    .op_b_i    (mul_b),
    .done_o    (mul_done),
    .product_o (mul_prod)
  );

  // Multiplier operand selection by state.
  always_comb begin
    case (state_q)
      mpc_pkg::ST_CR: begin
        mul_a = mpc_pkg::CoordW'(col_q);
        mul_b = {1'b0, step_x_q};
      end
      mpc_pkg::ST_CI: begin
        mul_a = mpc_pkg::CoordW'(row_q);
        mul_b = {1'b0, step_y_q};
      end
      mpc_pkg::ST_SQA: begin
        mul_a = a_q;
        mul_b = a_q;
      end
      mpc_pkg::ST_SQB: begin
        mul_a = b_q;
        mul_b = b_q;
      end
      default: begin
        mul_a = a_q;
        mul_b = b_q;
      end
    endcase
  end

  // Coordinate: min plus the low 64 bits of index * step, wrapping.
  assign coord_sum = ((state_q == mpc_pkg::ST_CR) ? min_x_q : min_y_q) +
                     mul_prod[mpc_pkg::CoordW-1:0];

  // z update: real and imaginary parts, floor-shifted and saturated.
  assign cr_ext = {{mpc_pkg::CoordW{cr_q[mpc_pkg::CoordW-1]}}, cr_q};
  assign ci_ext = {{mpc_pkg::CoordW{ci_q[mpc_pkg::CoordW-1]}}, ci_q};
  assign re_sum = diff_q + (cr_ext << FRAC_BITS);
  assign im_sum = ab_q + (ci_ext << (FRAC_BITS - 1));
  assign re_red = sat_reduce(mpc_pkg::ProdW'($signed(re_sum) >>> FRAC_BITS));
  assign im_red = sat_reduce(mpc_pkg::ProdW'($signed(im_sum) >>> (FRAC_BITS - 1)));

  // Escape test on the full-width squares of the new z.
  assign mag_sum   = aa_q + bb_q;
  assign beyond    = mag_sum > EscLimit;
  assign last_iter = (n_q + 12'd1) == iter_limit_q;
  assign esc_now   = ((state_q == mpc_pkg::ST_TEST) && !first_q && beyond) ||
                     ((state_q == mpc_pkg::ST_IM) && (sat_q || im_red[mpc_pkg::CoordW]));

  // Restoring divider by the iteration limit, one quotient bit per cycle.
  assign six_n      = (mpc_pkg::DivW'(n_q) << 2) + (mpc_pkg::DivW'(n_q) << 1);
  assign hue_scaled = (rem_q << 8) - rem_q;
  assign div_trial  = mpc_pkg::DivW'(iter_limit_q) << k_q;
  assign div_fits   = rem_q >= div_trial;
  assign rem_next   = div_fits ? (rem_q - div_trial) : rem_q;
  assign quo_next   = div_fits ? (quo_q | (8'd1 << k_q)) : quo_q;

  // Hue ramp from sector, quotient and remainder.
  assign rise = quo_q;
  assign fall = mpc_pkg::ColorMax - quo_q - 8'(rem_q != '0);

  always_comb begin
    red_c   = '0;
    green_c = '0;
    blue_c  = '0;
    if (esc_q) begin
      case (sec_q)
        3'd0: begin
          red_c   = mpc_pkg::ColorMax;
          green_c = rise;
        end
        3'd1: begin
          red_c   = fall;
          green_c = mpc_pkg::ColorMax;
        end
        3'd2: begin
          green_c = mpc_pkg::ColorMax;
          blue_c  = rise;
        end
        3'd3: begin
          green_c = fall;
          blue_c  = mpc_pkg::ColorMax;
        end
        3'd4: begin
          red_c  = rise;
          blue_c = mpc_pkg::ColorMax;
        end
        default: begin
          red_c  = mpc_pkg::ColorMax;
          blue_c = fall;
        end
      endcase
    end
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      mpc_pkg::ST_IDLE: if (in_valid_i) state_d = mpc_pkg::ST_CR;
      mpc_pkg::ST_CR:   if (mul_done) state_d = mpc_pkg::ST_CI;
      mpc_pkg::ST_CI: begin
        if (mul_done) begin
          state_d = (iter_limit_q == '0) ? mpc_pkg::ST_FIN : mpc_pkg::ST_SQA;
        end
      end
      mpc_pkg::ST_SQA:  if (mul_done) state_d = mpc_pkg::ST_SQB;
      mpc_pkg::ST_SQB:  if (mul_done) state_d = mpc_pkg::ST_TEST;
      mpc_pkg::ST_TEST: begin
        if (first_q) begin
          state_d = mpc_pkg::ST_AB;
        end else if (beyond) begin
          state_d = mpc_pkg::ST_DIVS;
        end else if (last_iter) begin
          state_d = mpc_pkg::ST_FIN;
        end else begin
          state_d = mpc_pkg::ST_AB;
        end
      end
      mpc_pkg::ST_AB:   if (mul_done) state_d = mpc_pkg::ST_RE1;
      mpc_pkg::ST_RE1:  state_d = mpc_pkg::ST_RE2;
      mpc_pkg::ST_RE2:  state_d = mpc_pkg::ST_IM;
      mpc_pkg::ST_IM:   state_d = esc_now ? mpc_pkg::ST_DIVS : mpc_pkg::ST_SQA;
      mpc_pkg::ST_DIVS: if (k_q == '0) state_d = mpc_pkg::ST_DIVM;
      mpc_pkg::ST_DIVM: state_d = mpc_pkg::ST_DIVH;
      mpc_pkg::ST_DIVH: if (k_q == '0) state_d = mpc_pkg::ST_FIN;
      mpc_pkg::ST_FIN:  if (!out_valid_q || out_ready_i) state_d = mpc_pkg::ST_IDLE;
      default:          state_d = mpc_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    mul_state = (state_q == mpc_pkg::ST_CR)  || (state_q == mpc_pkg::ST_CI) ||
                (state_q == mpc_pkg::ST_SQA) || (state_q == mpc_pkg::ST_SQB) ||
                (state_q == mpc_pkg::ST_AB);
    mul_start  = mul_state && !issued_q;
    in_ready_o = (state_q == mpc_pkg::ST_IDLE);
    out_load   = (state_q == mpc_pkg::ST_FIN) && (!out_valid_q || out_ready_i);
  end

  // Control registers and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mpc_pkg::ST_IDLE;
      issued_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      min_x_q      <= MinRst;
      min_y_q      <= MinRst;
      step_x_q     <= StepXRst;
      step_y_q     <= StepYRst;
      iter_limit_q <= IterLimitRst;
    end else begin
      state_q <= state_d;
      if (mul_done) begin
        issued_q <= 1'b0;
      end else if (mul_start) begin
        issued_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          mpc_pkg::REG_MIN_X:      min_x_q      <= cfg_data_i;
          mpc_pkg::REG_MIN_Y:      min_y_q      <= cfg_data_i;
          mpc_pkg::REG_STEP_X:     step_x_q     <= cfg_data_i[mpc_pkg::StepW-1:0];
          mpc_pkg::REG_STEP_Y:     step_y_q     <= cfg_data_i[mpc_pkg::StepW-1:0];
          mpc_pkg::REG_ITER_LIMIT: iter_limit_q <= cfg_data_i[mpc_pkg::IterW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Pixel datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      mpc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          col_q   <= column_i;
          row_q   <= row_i;
          n_q     <= '0;
          first_q <= 1'b1;
          esc_q   <= 1'b0;
        end
      end
      mpc_pkg::ST_CR: if (mul_done) cr_q <= coord_sum;
      mpc_pkg::ST_CI: begin
        if (mul_done) begin
          ci_q <= coord_sum;
          a_q  <= cr_q;
          b_q  <= coord_sum;
        end
      end
      mpc_pkg::ST_SQA: if (mul_done) aa_q <= mul_prod;
      mpc_pkg::ST_SQB: if (mul_done) bb_q <= mul_prod;
      mpc_pkg::ST_TEST: begin
        first_q <= 1'b0;
        if (!first_q && !beyond) begin
          n_q <= n_q + 12'd1;
        end
      end
      mpc_pkg::ST_AB:  if (mul_done) ab_q <= mul_prod;
      mpc_pkg::ST_RE1: diff_q <= aa_q - bb_q;
      mpc_pkg::ST_RE2: begin
        a_q   <= re_red[mpc_pkg::CoordW-1:0];
        sat_q <= re_red[mpc_pkg::CoordW];
      end
      mpc_pkg::ST_IM: b_q <= im_red[mpc_pkg::CoordW-1:0];
      mpc_pkg::ST_DIVS: begin
        rem_q <= rem_next;
        quo_q <= quo_next;
        k_q   <= k_q - 3'd1;
        if (k_q == '0) begin
          sec_q <= quo_next[mpc_pkg::SecW-1:0];
        end
      end
      mpc_pkg::ST_DIVM: begin
        rem_q <= hue_scaled;
        quo_q <= '0;
        k_q   <= DivHueTop;
      end
      mpc_pkg::ST_DIVH: begin
        rem_q <= rem_next;
        quo_q <= quo_next;
        k_q   <= k_q - 3'd1;
      end
      default: ;
    endcase
    // Escape: start the sector division of 6n by the iteration limit.
    if (esc_now) begin
      esc_q <= 1'b1;
      rem_q <= six_n;
      quo_q <= '0;
      k_q   <= DivSecTop;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q   <= red_c;
      green_q <= green_c;
      blue_q  <= blue_c;
      iter_q  <= n_q;
      escd_q  <= esc_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_o        = red_q;
  assign green_o      = green_q;
  assign blue_o       = blue_q;
  assign iterations_o = iter_q;
  assign escaped_o    = escd_q;

endmodule

FILE: hdl/mpc_checker.sv
// Port-level checks for the pixel colorer.
module mpc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [mpc_pkg::ColorW-1:0]   red_o,
  input logic [mpc_pkg::ColorW-1:0]   green_o,
  input logic [mpc_pkg::ColorW-1:0]   blue_o,
  input logic [mpc_pkg::IterW-1:0]    iterations_o,
  input logic                         escaped_o
);

  // Only one pixel is in flight: after an input transfer the block is busy.
  a_busy_after_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted again right after a transfer");

  // A pixel that does not escape is black.
  a_black_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !escaped_o |-> red_o == '0 && green_o == '0 && blue_o == '0)
    else $error("non-escaped pixel is not black");

  // Every hue sector keeps one component at full scale.
  a_hue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && escaped_o |->
      red_o == mpc_pkg::ColorMax || green_o == mpc_pkg::ColorMax ||
      blue_o == mpc_pkg::ColorMax)
    else $error("escaped pixel has no full-scale component");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_ready_i |=> out_valid_o && $stable(red_o) &&
      $stable(green_o) && $stable(blue_o) && $stable(iterations_o) &&
      $stable(escaped_o))
    else $error("stalled result changed");

endmodule

bind mandelbrot_pixel_color_core mpc_checker u_mpc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .red_o        (red_o),
  .green_o      (green_o),
  .blue_o       (blue_o),
  .iterations_o (iterations_o),
  .escaped_o    (escaped_o)
);
